// ===== rtl/hgps_pkg.sv =====
// Shared widths, configuration defaults and controller/datapath interface types
// for the hold-gesture port selector. No dependencies.
package hgps_pkg;

  localparam int TIME_BITS = 32;
  localparam int CNT_W     = $clog2(TIME_BITS + 1);

  localparam int DEB_W     = 10;
  localparam int BLINK_W   = 14;
  localparam int SLOT_W    = 14;
  localparam int LEAD_W    = 4;
  localparam int PORT_W    = 4;
  localparam int INDEX_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;
  localparam int LEADP_W   = LEAD_W + SLOT_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PORT  = 3'd5;

  // Reset values of the registers
  localparam logic [DEB_W-1:0]   DEF_DEBOUNCE  = 10'd20;
  localparam logic [BLINK_W-1:0] DEF_BLINK_ON  = 14'd400;
  localparam logic [BLINK_W-1:0] DEF_BLINK_OFF = 14'd200;
  localparam logic [SLOT_W-1:0]  DEF_SLOT      = 14'd600;
  localparam logic [LEAD_W-1:0]  DEF_LEAD      = 4'd5;
  localparam logic [PORT_W-1:0]  DEF_MAX_PORT  = 4'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic edge_upd;
    logic blink_upd;
    logic start_upd;
    logic sel_upd;
    logic div_step;
    logic div_wb;
    logic out_load;
  } hgps_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic go_div;
    logic div_done;
  } hgps_sts_t;

endpackage

// ===== rtl/hold_gesture_port_selector.sv =====
// Top level of the hold-gesture port selector: controller plus datapath.
// Depends on hgps_pkg, hgps_ctrl, hgps_dp (and hgps_div below it).
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per switch sample,
//   carrying in_now_ms (wrapping millisecond time) and in_level_low
//   (1 = pressed). Output channel (out_valid/out_ready): one transaction per
//   sample with the debounced held flag, blink flag, a release request
//   (valid and port) and the current selected index.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is
//   high; indexes 0..5 are debounce, blink on, blink off, slot, lead slots
//   and max port. Write only while no sample is in flight.
//   After acceptance the controller runs the edge, blink, start and select
//   updates and loads the output register, with a divide state before the
//   load when the index is recomputed: the restoring divider produces one
//   quotient bit per cycle over the 32-bit elapsed time. in_ready is high
//   only while the controller is idle, so a sample waits for the last; one
//   may be accepted while the previous result waits in the output register.
//   Stall: if out_ready stays low, the next result holds in the controller
//   until the output register frees, and no further sample is taken.
//   Reset (rst_n low, synchronous) restores the register defaults, clears
//   the gesture state and empties the output register.
module hold_gesture_port_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hgps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgps_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hgps_pkg::TIME_BITS-1:0]    in_now_ms,
  input  logic                              in_level_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_held,
  output logic                              out_blink,
  output logic                              out_request_valid,
  output logic [hgps_pkg::PORT_W-1:0]       out_request_port,
  output logic [hgps_pkg::INDEX_W-1:0]      out_selected_index
);
  import hgps_pkg::*;

  hgps_cmd_t cmd;
  hgps_sts_t sts;

  // Sequence the per-sample steps and run both handshakes
  hgps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold configuration and gesture state; drive the result payload
  hgps_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_now_ms          (in_now_ms),
    .in_level_low       (in_level_low),
    .cmd                (cmd),
    .sts                (sts),
    .out_held           (out_held),
    .out_blink          (out_blink),
    .out_request_valid  (out_request_valid),
    .out_request_port   (out_request_port),
    .out_selected_index (out_selected_index)
  );

endmodule

// ===== rtl/hgps_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high, for the port index.
// Depends on hgps_pkg.
module hgps_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              step,
  input  logic [hgps_pkg::TIME_BITS-1:0]    dividend,
  input  logic [hgps_pkg::SLOT_W-1:0]       divisor,
  output logic [hgps_pkg::TIME_BITS-1:0]    quotient,
  output logic                              done
);
  import hgps_pkg::*;

  logic [SLOT_W-1:0]    rem_r, rem_nxt;
  logic [TIME_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W:0]      trial;
  logic [SLOT_W:0]      diff;
  logic                 fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[TIME_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(TIME_BITS);
    end else if (step && cnt_r != '0) begin
      rem_nxt = fits ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
      quo_nxt = {quo_r[TIME_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = cnt_r == '0;

endmodule

// ===== rtl/hgps_dp.sv =====
// Datapath: configuration registers, gesture state, per-sample update steps
// and result registers. Depends on hgps_pkg and hgps_div.
module hgps_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hgps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgps_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic [hgps_pkg::TIME_BITS-1:0]    in_now_ms,
  input  logic                              in_level_low,
  input  hgps_pkg::hgps_cmd_t               cmd,
  output hgps_pkg::hgps_sts_t               sts,
  output logic                              out_held,
  output logic                              out_blink,
  output logic                              out_request_valid,
  output logic [hgps_pkg::PORT_W-1:0]       out_request_port,
  output logic [hgps_pkg::INDEX_W-1:0]      out_selected_index
);
  import hgps_pkg::*;

  // Configuration
  logic [DEB_W-1:0]   debounce_r;
  logic [BLINK_W-1:0] blink_on_r;
  logic [BLINK_W-1:0] blink_off_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [LEAD_W-1:0]  lead_r;
  logic [PORT_W-1:0]  max_port_r;

  // Sample and gesture state
  logic [TIME_BITS-1:0] t_r;
  logic                 pressed_r;
  logic                 held_r;
  logic [TIME_BITS-1:0] last_edge_r;
  logic                 blink_r;
  logic [TIME_BITS-1:0] due_r;
  logic                 selecting_r;
  logic [INDEX_W-1:0]   count_r;
  logic [TIME_BITS-1:0] start_r;
  logic                 req_valid_r;
  logic [PORT_W-1:0]    req_port_r;

  logic [TIME_BITS-1:0] edge_limit;
  logic                 edge_ok;
  logic                 blink_new;
  logic [TIME_BITS-1:0] blink_period;
  logic [LEADP_W-1:0]   lead_len;
  logic [TIME_BITS-1:0] slot_end;
  logic [TIME_BITS-1:0] delta;
  logic [TIME_BITS-1:0] quotient;
  logic                 div_done;

  assign edge_limit   = last_edge_r + TIME_BITS'(debounce_r);
  assign edge_ok      = (held_r != pressed_r) && (t_r > edge_limit);
  assign blink_new    = ~blink_r;
  assign blink_period = TIME_BITS'(blink_new ? blink_on_r : blink_off_r);
  assign lead_len     = LEADP_W'(lead_r) * LEADP_W'(slot_r);
  assign slot_end     = start_r + TIME_BITS'(slot_r);
  assign delta        = t_r - start_r;

  assign sts.go_div   = held_r && selecting_r && (t_r >= slot_end);
  assign sts.div_done = div_done;

  hgps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sel_upd && sts.go_div),
    .step     (cmd.div_step),
    .dividend (delta),
    .divisor  (slot_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEF_DEBOUNCE;
      blink_on_r  <= DEF_BLINK_ON;
      blink_off_r <= DEF_BLINK_OFF;
      slot_r      <= DEF_SLOT;
      lead_r      <= DEF_LEAD;
      max_port_r  <= DEF_MAX_PORT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  debounce_r  <= cfg_wdata[DEB_W-1:0];
        REG_BLINK_ON:  blink_on_r  <= cfg_wdata[BLINK_W-1:0];
        REG_BLINK_OFF: blink_off_r <= cfg_wdata[BLINK_W-1:0];
        REG_SLOT:      slot_r      <= cfg_wdata[SLOT_W-1:0];
        REG_LEAD:      lead_r      <= cfg_wdata[LEAD_W-1:0];
        REG_MAX_PORT:  max_port_r  <= cfg_wdata[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r       <= in_now_ms;
      pressed_r <= in_level_low;
    end
    if (cmd.start_upd) begin
      start_r <= last_edge_r + TIME_BITS'(lead_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      last_edge_r <= '0;
      blink_r     <= 1'b0;
      due_r       <= '0;
      selecting_r <= 1'b0;
      count_r     <= '0;
      req_valid_r <= 1'b0;
      req_port_r  <= '0;
    end else begin
      if (cmd.load) begin
        req_valid_r <= 1'b0;
        req_port_r  <= '0;
      end
      // Accept a debounced level change and restart the blink timer
      if (cmd.edge_upd && edge_ok) begin
        held_r      <= pressed_r;
        last_edge_r <= t_r;
        blink_r     <= 1'b0;
        due_r       <= t_r + TIME_BITS'(blink_on_r);
      end
      // Toggle the blink flag when the running timer expires
      if (cmd.blink_upd && due_r != '0 && t_r > due_r) begin
        blink_r <= blink_new;
        due_r   <= t_r + blink_period;
      end
      if (cmd.sel_upd) begin
        if (held_r) begin
          if (!selecting_r && t_r >= start_r) begin
            selecting_r <= 1'b1;
          end
        end else if (selecting_r) begin
          if (count_r != '0 && count_r <= INDEX_W'(max_port_r)) begin
            req_valid_r <= 1'b1;
            req_port_r  <= count_r[PORT_W-1:0];
          end
          selecting_r <= 1'b0;
          count_r     <= '0;
          blink_r     <= 1'b0;
          due_r       <= '0;
        end
      end
      if (cmd.div_wb) begin
        count_r <= quotient[INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_held           <= held_r;
      out_blink          <= blink_r;
      out_request_valid  <= req_valid_r;
      out_request_port   <= req_port_r;
      out_selected_index <= count_r;
    end
  end

endmodule

// ===== rtl/hgps_ctrl.sv =====
// Controller: sequences the update steps of one sample and owns both
// handshakes. Depends on hgps_pkg.
module hgps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  hgps_pkg::hgps_sts_t sts,
  output hgps_pkg::hgps_cmd_t cmd
);
  import hgps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EDGE  = 3'd1;
  localparam logic [2:0] S_BLINK = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = S_BLINK;
      end
      S_BLINK: begin
        cmd.blink_upd = 1'b1;
        state_nxt     = S_START;
      end
      S_START: begin
        cmd.start_upd = 1'b1;
        state_nxt     = S_SEL;
      end
      S_SEL: begin
        cmd.sel_upd = 1'b1;
        state_nxt   = sts.go_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EDGE)
    else $error("accepted sample did not start the update sequence");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_ready |=> state_r == S_OUT && out_valid_r)
    else $error("result register overwritten while receiver stalls");

  a_no_div_skip: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEL && sts.go_div |=> state_r == S_DIV && !sts.div_done)
    else $error("division did not start after selection step");

endmodule
